### sv/rsce_pkg.sv
// Shared types and constants for the read soft clip extension block.
package rsce_pkg;

	// Default maximum number of base pairs stored per read
	localparam int MAX_READ_LEN_DEF = 128;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int PEN_W = 4;
	localparam logic [PEN_W-1:0] PENALTY_RESET = 4'd2;
	localparam logic REG_MISMATCH_PENALTY = 1'b0;

	// One aligned base pair of the read
	typedef struct packed {
		logic [1:0] read_base;
		logic [1:0] ref_base;
		logic       last_pair;
	} in_t;

	// Clip result for one read
	typedef struct packed {
		logic signed [7:0] clip_begin;
		logic signed [7:0] clip_end;
		logic              left_clipped;
		logic              right_clipped;
		logic [7:0]        read_length;
	} out_t;

endpackage

### sv/rsce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsce_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/read_soft_clip_extension.sv
// Top level: loads a read's match flags, then scans right and left from the middle for clips.
//
//   channel   dir  signals                               transfer when
//   in        in   in_valid, in_ready, in_data (in_t)    in_valid & in_ready
//   out       out  out_valid, out_ready, out_data (out_t) out_valid & out_ready
//   cfg       in   psel, penable, pwrite, paddr, pwdata  psel & penable & pwrite (pready = 1)
//
// One pair per cycle while loading; after the last pair the block scans the match flag RAM
// (one flag per cycle through its single read port and the shared score adder), then passes
// through a drain state and a state that loads the result.
// Reset clears the sequencer, the pair count and sets the penalty to 2; the flag RAM is not
// cleared. in_ready is low from the last pair until the result is written to the output
// register; pairs of the next read are taken while that result waits for out_ready.
module read_soft_clip_extension #(
	parameter int MAX_READ_LEN = rsce_pkg::MAX_READ_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rsce_pkg::APB_AW-1:0] paddr,
	input  logic [rsce_pkg::APB_DW-1:0] pwdata,
	output logic [rsce_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rsce_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rsce_pkg::out_t              out_data
);

	localparam int IDX_W = $clog2(MAX_READ_LEN);
	localparam int CW    = $clog2(MAX_READ_LEN + 1);
	localparam int SW    = IDX_W + 6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN_R,
		ST_SCAN_L,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [rsce_pkg::PEN_W-1:0] pen_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              len_q;
	logic [IDX_W-1:0]           mid_q;
	logic [IDX_W-1:0]           k_q;

	logic                       valid_s1;
	logic                       first_s1;
	logic                       left_s1;
	logic [IDX_W-1:0]           idx_s1;

	logic signed [SW-1:0]       score_q;
	logic signed [SW-1:0]       best_q;
	logic                       end_found_q;
	logic [IDX_W-1:0]           end_idx_q;
	logic                       begin_found_q;
	logic [IDX_W-1:0]           begin_idx_q;

	logic                       out_valid_q;
	rsce_pkg::out_t             out_data_q;

	logic                       in_xfer;
	logic                       room;
	logic [CW-1:0]              new_len;
	logic                       flag_rd;
	logic signed [SW-1:0]       score_base;
	logic signed [SW-1:0]       best_base;
	logic signed [SW-1:0]       pen_ext;
	logic signed [SW-1:0]       score_nxt;
	logic                       improve;
	logic                       cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == rsce_pkg::REG_MISMATCH_PENALTY);
	assign prdata = (paddr[2] == rsce_pkg::REG_MISMATCH_PENALTY)
		? rsce_pkg::APB_DW'(pen_q) : '0;

	// Load side
	assign in_ready = (state_q == ST_LOAD);
	assign in_xfer  = in_valid && in_ready;
	assign room     = count_q < CW'(MAX_READ_LEN);
	assign new_len  = room ? count_q + CW'(1) : count_q;

	rsce_ram #(
		.WIDTH(1),
		.DEPTH(MAX_READ_LEN)
	) u_flags (
		.clk  (clk),
		.we   (in_xfer && room),
		.waddr(IDX_W'(count_q)),
		.wdata(in_data.read_base == in_data.ref_base),
		.raddr(k_q),
		.rdata(flag_rd)
	);

	// Shared score unit: one flag per cycle, restarting at the first offset of each scan
	assign score_base = first_s1 ? '0 : score_q;
	assign best_base  = first_s1 ? '0 : best_q;
	assign pen_ext    = signed'(SW'(pen_q));
	assign score_nxt  = flag_rd ? score_base + SW'(1) : score_base - pen_ext;
	assign improve    = score_nxt > best_base;

	// Sequencer, scan pipeline and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			pen_q         <= rsce_pkg::PENALTY_RESET;
			count_q       <= '0;
			len_q         <= '0;
			mid_q         <= '0;
			k_q           <= '0;
			valid_s1      <= 1'b0;
			first_s1      <= 1'b0;
			left_s1       <= 1'b0;
			idx_s1        <= '0;
			score_q       <= '0;
			best_q        <= '0;
			end_found_q   <= 1'b0;
			end_idx_q     <= '0;
			begin_found_q <= 1'b0;
			begin_idx_q   <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			if (cfg_wr) begin
				pen_q <= pwdata[rsce_pkg::PEN_W-1:0];
			end

			// drop the result once taken; the result stage reloads it on its own
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end

			// process the flag issued last cycle
			if (valid_s1) begin
				score_q <= score_nxt;
				if (improve) begin
					best_q <= score_nxt;
				end else begin
					best_q <= best_base;
				end
				if (left_s1) begin
					begin_found_q <= improve || (!first_s1 && begin_found_q);
					if (improve) begin
						begin_idx_q <= idx_s1;
					end
				end else begin
					end_found_q <= improve || (!first_s1 && end_found_q);
					if (improve) begin
						end_idx_q <= idx_s1;
					end
				end
			end

			case (state_q)
				ST_LOAD: begin
					valid_s1 <= 1'b0;
					if (in_xfer) begin
						if (in_data.last_pair) begin
							len_q   <= new_len;
							mid_q   <= IDX_W'(new_len >> 1);
							k_q     <= IDX_W'(new_len >> 1);
							count_q <= '0;
							state_q <= ST_SCAN_R;
						end else begin
							count_q <= new_len;
						end
					end
				end
				ST_SCAN_R: begin
					valid_s1 <= 1'b1;
					first_s1 <= (k_q == mid_q);
					left_s1  <= 1'b0;
					idx_s1   <= k_q;
					if (CW'(k_q) == len_q - CW'(1)) begin
						k_q     <= mid_q;
						state_q <= ST_SCAN_L;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_SCAN_L: begin
					valid_s1 <= 1'b1;
					first_s1 <= (k_q == mid_q);
					left_s1  <= 1'b1;
					idx_s1   <= k_q;
					if (k_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q - IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					valid_s1 <= 1'b0;
					state_q  <= ST_FIN;
				end
				ST_FIN: begin
					valid_s1 <= 1'b0;
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q              <= 1'b1;
						out_data_q.clip_begin    <= begin_found_q ? 8'(begin_idx_q) : '1;
						out_data_q.clip_end      <= end_found_q ? 8'(end_idx_q) : '1;
						out_data_q.left_clipped  <= !(begin_found_q && begin_idx_q == '0);
						out_data_q.right_clipped <=
							!(end_found_q && CW'(end_idx_q) == len_q - CW'(1));
						out_data_q.read_length   <= 8'(len_q);
						state_q                  <= ST_LOAD;
					end
				end
				default: begin
					valid_s1 <= 1'b0;
					state_q  <= ST_LOAD;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Pair count never passes the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_READ_LEN))
		else $error("pair count beyond store depth");

	// Scan offsets stay inside the loaded read
	a_scan_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_R || state_q == ST_SCAN_L) |-> (CW'(k_q) < len_q))
		else $error("scan offset outside read");

	// Score pipeline is empty whenever loading or emitting
	a_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD || state_q == ST_FIN) |-> !valid_s1)
		else $error("score pipeline busy outside scan");

	// A result is only loaded after the left scan drained
	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> ($past(state_q) == ST_DRAIN || $past(state_q) == ST_FIN))
		else $error("result stage entered without drain");

endmodule

### tb/read_soft_clip_extension_tb.sv
// Self-checking testbench for the read soft clip extension block.
`timescale 1ns / 100ps

module read_soft_clip_extension_tb;

	localparam int READ_CAP = rsce_pkg::MAX_READ_LEN_DEF;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_PAIRS = 200;
	localparam int PHASE_PAIRS = 70;
	localparam logic [rsce_pkg::APB_AW-1:0] PENALTY_ADDR =
		rsce_pkg::APB_AW'(4 * rsce_pkg::REG_MISMATCH_PENALTY);

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [rsce_pkg::APB_AW-1:0]   paddr;
	logic [rsce_pkg::APB_DW-1:0]   pwdata;
	logic [rsce_pkg::APB_DW-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	rsce_pkg::in_t                 in_data;
	logic                          out_valid;
	logic                          out_ready;
	rsce_pkg::out_t                out_data;

	// Predictor state: match flag per offset, pairs kept so far, current penalty
	bit                            flag_mem [READ_CAP];
	int                            pair_cnt;
	logic [rsce_pkg::PEN_W-1:0]    penalty_q;
	rsce_pkg::out_t                pending_clips [$];
	int                            fail_count;
	int                            cycle_cnt;
	bit                            steady;

	read_soft_clip_extension u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("read_soft_clip_extension verification failed");
			$finish;
		end
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 6);
	endfunction

	// Scan from start to stop inclusive; return the last offset where the score beat the best
	function automatic int scan_best(int start, int stop, int dir);
		int score;
		int best;
		int best_k;
		int k;
		score = 0;
		best = 0;
		best_k = -1;
		k = start;
		while (1'b1) begin
			if (flag_mem[k])
				score += 1;
			else
				score -= int'(penalty_q);
			if (score > best) begin
				best = score;
				best_k = k;
			end
			if (k == stop)
				break;
			k += dir;
		end
		return best_k;
	endfunction

	// Store one accepted pair; on the last pair compute the clip result
	function automatic void predict_clip(rsce_pkg::in_t p);
		int mid;
		int end_k;
		int begin_k;
		rsce_pkg::out_t clip;
		if (pair_cnt < READ_CAP) begin
			flag_mem[pair_cnt] = (p.read_base == p.ref_base);
			pair_cnt++;
		end
		if (p.last_pair) begin
			mid = pair_cnt / 2;
			end_k = scan_best(mid, pair_cnt - 1, 1);
			begin_k = scan_best(mid, 0, -1);
			clip.clip_begin = begin_k[7:0];
			clip.clip_end = end_k[7:0];
			clip.left_clipped = (begin_k != 0);
			clip.right_clipped = (end_k != pair_cnt - 1);
			clip.read_length = pair_cnt[7:0];
			pending_clips.push_back(clip);
			pair_cnt = 0;
		end
	endfunction

	function automatic rsce_pkg::in_t make_pair(logic [1:0] rb, logic [1:0] fb, logic last);
		rsce_pkg::in_t p;
		p.read_base = rb;
		p.ref_base = fb;
		p.last_pair = last;
		return p;
	endfunction

	// Random bases that match or differ as asked
	function automatic rsce_pkg::in_t random_pair(bit same, logic last);
		logic [1:0] rb;
		rb = 2'($urandom_range(0, 3));
		return make_pair(rb, same ? rb : rb + 2'($urandom_range(1, 3)), last);
	endfunction

	// Send one pair; returns at the falling edge after its transfer with valid still high
	task automatic send_pair(rsce_pkg::in_t p);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_clip(p);
		@(negedge clk);
	endtask

	task automatic send_read(int len, int match_pct);
		for (int i = 0; i < len; i++)
			send_pair(random_pair($urandom_range(1, 100) <= match_pct, i == len - 1));
	endtask

	// Drop valid, wait for all results, then let the scan sequencer settle
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_clips.size() != 0) @(negedge clk);
		repeat (READ_CAP + 8) @(negedge clk);
	endtask

	// Write the penalty register while idle, then read it back
	task automatic write_penalty(logic [rsce_pkg::PEN_W-1:0] value);
		logic [rsce_pkg::APB_DW-1:0] word;
		word = $urandom();
		word[rsce_pkg::PEN_W-1:0] = value;
		settle_block();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= PENALTY_ADDR;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penalty_q = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[rsce_pkg::PEN_W-1:0] !== value) begin
			$error("mismatch_penalty: expected %0d, got %0d", value,
				prdata[rsce_pkg::PEN_W-1:0]);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Compare one result transfer against the oldest expectation
	task automatic check_clip(rsce_pkg::out_t got);
		rsce_pkg::out_t want;
		if (pending_clips.size() == 0) begin
			$error("unexpected result: clip_begin %0d clip_end %0d", got.clip_begin,
				got.clip_end);
			fail_count++;
			return;
		end
		want = pending_clips.pop_front();
		if (got.clip_begin !== want.clip_begin) begin
			$error("clip_begin: expected %0d, got %0d", want.clip_begin, got.clip_begin);
			fail_count++;
		end
		if (got.clip_end !== want.clip_end) begin
			$error("clip_end: expected %0d, got %0d", want.clip_end, got.clip_end);
			fail_count++;
		end
		if (got.left_clipped !== want.left_clipped) begin
			$error("left_clipped: expected %0d, got %0d", want.left_clipped, got.left_clipped);
			fail_count++;
		end
		if (got.right_clipped !== want.right_clipped) begin
			$error("right_clipped: expected %0d, got %0d", want.right_clipped,
				got.right_clipped);
			fail_count++;
		end
		if (got.read_length !== want.read_length) begin
			$error("read_length: expected %0d, got %0d", want.read_length, got.read_length);
			fail_count++;
		end
	endtask

	// Result side: stall at random, check every transfer
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_clip(out_data);
			@(negedge clk);
		end
	end

	// Short reads, field extremes, all-match, all-mismatch and clipped ends at reset penalty
	task automatic test_directed();
		send_pair(make_pair(2'd3, 2'd3, 1'b1));
		send_pair(make_pair(2'd0, 2'd3, 1'b1));
		send_pair(make_pair(2'd0, 2'd0, 1'b0));
		send_pair(make_pair(2'd3, 2'd0, 1'b1));
		send_pair(make_pair(2'd1, 2'd1, 1'b0));
		send_pair(make_pair(2'd2, 2'd2, 1'b0));
		send_pair(make_pair(2'd3, 2'd3, 1'b0));
		send_pair(make_pair(2'd0, 2'd0, 1'b1));
		send_pair(make_pair(2'd2, 2'd1, 1'b0));
		send_pair(make_pair(2'd1, 2'd1, 1'b0));
		send_pair(make_pair(2'd3, 2'd3, 1'b0));
		send_pair(make_pair(2'd2, 2'd2, 1'b0));
		send_pair(make_pair(2'd0, 2'd3, 1'b1));
		send_pair(make_pair(2'd1, 2'd2, 1'b0));
		send_pair(make_pair(2'd3, 2'd0, 1'b0));
		send_pair(make_pair(2'd2, 2'd1, 1'b1));
		send_pair(make_pair(2'd1, 2'd1, 1'b0));
		send_pair(make_pair(2'd0, 2'd1, 1'b0));
		send_pair(make_pair(2'd2, 2'd2, 1'b0));
		send_pair(make_pair(2'd3, 2'd1, 1'b1));
	endtask

	// Sweep the penalty, extremes included; zero penalty leaves the score on a mismatch
	task automatic test_penalty_range();
		logic [rsce_pkg::PEN_W-1:0] settings [6];
		settings = '{4'd0, 4'd15, 4'd1, 4'd7, 4'd3, rsce_pkg::PENALTY_RESET};
		foreach (settings[s]) begin
			write_penalty(settings[s]);
			for (int r = 0; r < 3; r++)
				send_read($urandom_range(1, 16), $urandom_range(40, 100));
		end
	endtask

	// Reads at and past the flag store depth; a dropped last pair still closes the read
	task automatic test_overlong();
		send_read(READ_CAP, 85);
		send_read(READ_CAP + 2, 60);
	endtask

	// Random reads, mostly short, with the penalty changed between phases
	task automatic test_random();
		int sent;
		int phase_sent;
		int len;
		int pick;
		sent = 0;
		phase_sent = 0;
		while (sent < RANDOM_PAIRS) begin
			if (phase_sent >= PHASE_PAIRS) begin
				pick = $urandom_range(0, 3);
				write_penalty(pick == 0 ? 4'd0 : pick == 1 ? 4'd15 :
					rsce_pkg::PEN_W'($urandom_range(0, 15)));
				phase_sent = 0;
			end
			pick = $urandom_range(0, 24);
			if (pick < 20)
				len = $urandom_range(1, 10);
			else if (pick < 24)
				len = $urandom_range(11, 48);
			else
				len = $urandom_range(49, READ_CAP);
			steady = ($urandom_range(0, 3) == 0);
			send_read(len, $urandom_range(0, 100));
			sent += len;
			phase_sent += len;
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		fail_count = 0;
		pair_cnt = 0;
		penalty_q = rsce_pkg::PENALTY_RESET;
		steady = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_penalty_range();
		test_overlong();
		test_random();

		// Drain, then watch for stray results
		in_valid <= 1'b0;
		while (pending_clips.size() != 0) @(posedge clk);
		repeat (READ_CAP + 8) @(posedge clk);
		if (fail_count == 0)
			$display("read_soft_clip_extension verification clean");
		else
			$display("read_soft_clip_extension verification failed");
		$finish;
	end

endmodule
